FILE: design/bhpq_pkg.sv
`timescale 1ns / 1ps
package bhpq_pkg;
    localparam int CAPACITY_DEF      = 1024;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int COUNT_W           = 11;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LWAIT,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } state_t;
endpackage

FILE: design/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// An insert sifts up, one parent compared per step; a remove sifts down, one child pair compared
// per step; a refused (full) insert and an empty remove only report status.
// Flow: one item in flight; the next word is taken as soon as the result is
// registered, also while that result still waits on m_tready.
// Reset: aresetn clears count and control; heap memory is not cleared,
// only entries below the count are ever used.
module binary_min_heap_priority_queue #(
    parameter int CAPACITY      = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode[0], key[32:1], payload[64:33], zero[71:65]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], top_valid[2], top_key[34:3],
                                   // top_payload[66:35], count[77:67], zero[79:78]
);
    import bhpq_pkg::*;

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;       // 1-based slot of the hole
    logic [EW-1:0] mov_reg, mov_next;       // element being sifted
    logic [EW-1:0] lch_reg, lch_next;
    logic [1:0]    stat_reg, stat_next;
    logic [77:0]   out_reg, out_next;
    logic          ov_reg, ov_next;

    function automatic logic less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        return $signed(a[EW-1 -: KEY_WIDTH]) < $signed(b[EW-1 -: KEY_WIDTH]);
    endfunction

    // memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    logic [CW-1:0] par;
    logic [CW:0]   lc, rc;
    logic [EW-1:0] in_elem, chosen;
    logic          pick_r;
    assign par = idx_reg >> 1;
    assign lc  = {idx_reg, 1'b0};
    assign rc  = {idx_reg, 1'b1};
    assign in_elem = {s_tdata[KEY_WIDTH:1], s_tdata[32+PAYLOAD_WIDTH:33]};
    // right child wins on tie
    assign pick_r = (rc <= {1'b0, cnt_reg}) && !less(lch_reg, rdata_reg);
    assign chosen = pick_r ? rdata_reg : lch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
        idx_reg  <= idx_next;
        mov_reg  <= mov_next;
        lch_reg  <= lch_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, out_reg};

    always_comb begin
        logic [31:0] tk, tp;
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        mov_next = mov_reg;
        lch_next = lch_reg;
        stat_next = stat_reg;
        out_next = out_reg;
        ov_next = ov_reg && !m_tready;
        we = 1'b0;
        waddr = '0;
        wdata = mov_reg;
        raddr = '0;
        tk = '0;
        tp = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tdata[0] == OP_INSERT) begin
                        if (cnt_reg >= CW'(CAPACITY)) begin
                            stat_next = ST_FULL;
                            state_next = S_TOP_RD;
                        end else begin
                            stat_next = ST_DONE;
                            mov_next = in_elem;
                            cnt_next = cnt_reg + CW'(1);
                            idx_next = cnt_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            stat_next = ST_EMPTY;
                            state_next = S_OUT;
                        end else begin
                            stat_next = ST_DONE;
                            cnt_next = cnt_reg - CW'(1);
                            idx_next = CW'(1);
                            state_next = S_DN_LAST;
                        end
                    end
                end
            end
            // read parent or place at root
            S_UP_RD: begin
                if (par == '0) begin
                    we = 1'b1;
                    waddr = AW'(idx_reg - CW'(1));
                    state_next = S_TOP_RD;
                end else begin
                    raddr = AW'(par - CW'(1));
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                waddr = AW'(idx_reg - CW'(1));
                if (less(mov_reg, rdata_reg)) begin
                    wdata = rdata_reg;
                    idx_next = par;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_TOP_RD;
                end
            end
            // fetch last element (address cnt after decrement)
            S_DN_LAST: begin
                raddr = AW'(cnt_reg);
                state_next = S_DN_LWAIT;
            end
            S_DN_LWAIT: begin
                mov_next = rdata_reg;
                state_next = (cnt_reg == '0) ? S_OUT : S_DN_RDL;
            end
            S_DN_RDL: begin
                if (lc > {1'b0, cnt_reg}) begin
                    we = 1'b1;
                    waddr = AW'(idx_reg - CW'(1));
                    state_next = S_TOP_RD;
                end else begin
                    raddr = AW'(lc - (CW+1)'(1));
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                lch_next = rdata_reg;
                raddr = AW'(lc);
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                we = 1'b1;
                waddr = AW'(idx_reg - CW'(1));
                if (less(mov_reg, chosen)) begin
                    state_next = S_TOP_RD;
                end else begin
                    wdata = chosen;
                    idx_next = CW'(pick_r ? rc : lc);
                    state_next = S_DN_RDL;
                end
            end
            S_TOP_RD: begin
                raddr = '0;
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!ov_reg) begin
                    if (cnt_reg != '0) begin
                        tk = 32'($signed(rdata_reg[EW-1 -: KEY_WIDTH]));
                        tp = 32'(rdata_reg[PAYLOAD_WIDTH-1:0]);
                    end
                    out_next = {COUNT_W'(cnt_reg), tp, tk, (cnt_reg != '0), stat_reg};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

FILE: tb/sv/binary_min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
module binary_min_heap_priority_queue_tb;
    import bhpq_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [31:0] payload;
        logic [31:0] key;
        logic        opcode;
    } heap_cmd_t;

    typedef struct packed {
        logic [10:0] count;
        logic [31:0] top_payload;
        logic [31:0] top_key;
        logic        top_valid;
        logic [1:0]  status;
    } heap_rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    heap_cmd_t cmd_queue[$];
    heap_rsp_t rsp_expected[$];
    int        err_count;
    bit        stim_done;
    int        hold_cycles;

    // shadow heap
    logic signed [31:0] sh_key[CAP];
    logic [31:0]        sh_pay[CAP];
    int                 sh_count;

    binary_min_heap_priority_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // opcode, key, payload
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // status, top_valid, top_key, top_payload, count
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // apply one command to the shadow heap and return the expected word
    function automatic heap_rsp_t heap_apply(heap_cmd_t c);
        heap_rsp_t          r;
        int                 i, par, ch;
        logic signed [31:0] k;
        logic [31:0]        p;
        r = '0;
        r.status = ST_DONE;
        if (c.opcode == OP_INSERT) begin
            if (sh_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                k = c.key;
                p = c.payload;
                sh_count++;
                i = sh_count;
                par = i / 2;
                while (par != 0 && k < sh_key[par-1]) begin
                    sh_key[i-1] = sh_key[par-1];
                    sh_pay[i-1] = sh_pay[par-1];
                    i = par;
                    par = i / 2;
                end
                sh_key[i-1] = k;
                sh_pay[i-1] = p;
            end
        end else begin
            if (sh_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                sh_count--;
                k = sh_key[sh_count];
                p = sh_pay[sh_count];
                i = 1;
                if (sh_count != 0) begin
                    while (i <= sh_count / 2) begin
                        ch = 2 * i;
                        if (ch < sh_count && !(sh_key[ch-1] < sh_key[ch]))
                            ch++;
                        if (k < sh_key[ch-1])
                            break;
                        sh_key[i-1] = sh_key[ch-1];
                        sh_pay[i-1] = sh_pay[ch-1];
                        i = ch;
                    end
                    sh_key[i-1] = k;
                    sh_pay[i-1] = p;
                end
            end
        end
        if (sh_count != 0) begin
            r.top_valid   = 1'b1;
            r.top_key     = sh_key[0];
            r.top_payload = sh_pay[0];
        end
        r.count = sh_count[10:0];
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 6) ? 0 :
               ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic heap_cmd_t mk_cmd(logic op, logic [31:0] k, logic [31:0] p);
        heap_cmd_t c;
        c.opcode = op;
        c.key = k;
        c.payload = p;
        return c;
    endfunction

    // random key: mostly narrow range to get duplicates, sometimes full range
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 7);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'h7FFF_FFFC + $urandom_range(0, 3);
        endcase
    endfunction

    // capture input handshake at the rising edge
    logic s_tready_q;
    always @(posedge aclk) s_tready_q <= s_tvalid && s_tready;

    // driver: pop pending commands, predict on acceptance
    int drv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_gap  = 0;
        end else begin
            if (s_tvalid && s_tready_q) begin
                rsp_expected.push_back(heap_apply(cmd_queue.pop_front()));
                drv_gap = gap_len();
            end
            if (drv_gap > 0) begin
                drv_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, cmd_queue[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    heap_rsp_t got, exp_r;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[77:0];
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                err_count++;
            end else begin
                exp_r = rsp_expected.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    err_count++;
                end
                if (got.top_valid !== exp_r.top_valid) begin
                    $display("%0t: top_valid exp %0d got %0d", $time,
                             exp_r.top_valid, got.top_valid);
                    err_count++;
                end
                if (got.top_key !== exp_r.top_key) begin
                    $display("%0t: top_key exp %h got %h", $time, exp_r.top_key, got.top_key);
                    err_count++;
                end
                if (got.top_payload !== exp_r.top_payload) begin
                    $display("%0t: top_payload exp %h got %h", $time,
                             exp_r.top_payload, got.top_payload);
                    err_count++;
                end
                if (got.count !== exp_r.count) begin
                    $display("%0t: count exp %0d got %0d", $time, exp_r.count, got.count);
                    err_count++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off
    int rcv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_gap  = 0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rcv_gap = gap_len();
        end
    end

    // stimulus
    initial begin
        int n, burst, target;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        aresetn  = 1'b0;
        err_count = 0;
        stim_done = 1'b0;
        hold_cycles = 0;
        sh_count = 0;

        // directed: empty remove, extremes, ties
        cmd_queue.push_back(mk_cmd(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h8000_0000, 32'h0000_0000));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h0000_0000, 32'hAAAA_5555));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h0000_0005, 32'h1));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h0000_0005, 32'h2));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h0000_0005, 32'h3));
        repeat (8) cmd_queue.push_back(mk_cmd(OP_REMOVE, 32'h0, 32'h0));

        repeat (2) @(posedge aclk);
        #1 aresetn = 1'b1;

        // long receiver hold-off while commands keep arriving
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'd9, 32'd9));
        repeat (10) cmd_queue.push_back(mk_cmd(OP_INSERT, rand_key(), $urandom()));
        hold_cycles = 400;

        // fill to capacity with refused inserts, then partly drain
        n = 0;
        while (n < CAP - 11) begin
            cmd_queue.push_back(mk_cmd(OP_INSERT, rand_key(), $urandom()));
            n++;
        end
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk_cmd(OP_INSERT, 32'h1234, 32'h1));
        n = 0;
        while (n < CAP - 160) begin
            cmd_queue.push_back(mk_cmd(OP_REMOVE, $urandom(), $urandom()));
            n++;
        end

        // random mixed traffic, biased bursts
        n = 0;
        while (n < 40) begin
            burst = $urandom_range(1, 12);
            target = $urandom_range(0, 1);
            repeat (burst) begin
                cmd_queue.push_back(mk_cmd(($urandom_range(0, 3) == 0) ? ~target[0] : target[0],
                                           rand_key(), $urandom()));
                n++;
            end
        end

        wait (cmd_queue.size() == 0);
        wait (rsp_expected.size() == 0);
        repeat (100) @(posedge aclk);
        if (err_count == 0)
            $display("binary_min_heap_priority_queue_tb: clean");
        else
            $display("binary_min_heap_priority_queue_tb: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("binary_min_heap_priority_queue_tb: errors");
        $finish;
    end
endmodule

FILE: sim.f
design/bhpq_pkg.sv
design/binary_min_heap_priority_queue.sv
tb/sv/binary_min_heap_priority_queue_tb.sv
